FILE: rtl/core/mtspr_pkg.sv
// shared types, constants and helpers for the tile and sprite pixel renderer
// no dependencies
`default_nettype none
package mtspr_pkg;
  localparam int VideoBytes = 8192;
  localparam int SpriteCount = 40;
  localparam int ScreenWidth = 160;
  localparam int ScreenHeight = 144;
  localparam int TableBytes = 4 * SpriteCount;
  localparam int VaW = $clog2(VideoBytes);
  localparam int SaW = $clog2(TableBytes);
  localparam int SiW = $clog2(SpriteCount);
  localparam logic [SiW-1:0] LastSprite = SiW'(SpriteCount - 1);

  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_VWRITE = 2'd1;
  localparam logic [1:0] OP_SWRITE = 2'd2;

  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_SCX = 3'd1;
  localparam logic [2:0] REG_SCY = 3'd2;
  localparam logic [2:0] REG_WX = 3'd3;
  localparam logic [2:0] REG_WY = 3'd4;
  localparam logic [2:0] REG_BGP = 3'd5;
  localparam logic [2:0] REG_OBP0 = 3'd6;
  localparam logic [2:0] REG_OBP1 = 3'd7;

  localparam logic [12:0] MapLow = 13'h1800;
  localparam logic [12:0] MapHigh = 13'h1C00;
  localparam logic [12:0] TileSigned = 13'h0800;

  // queued item between front and back
  typedef struct packed {
    logic [1:0] op;
    logic [12:0] addr;
    logic [7:0] data;
    logic [7:0] line;
    logic [7:0] column;
  } item_t;

  function automatic logic [1:0] map_shade(input logic [7:0] pal, input logic [1:0] dot);
    map_shade = pal[{dot, 1'b1} -: 2];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/mono_tile_sprite_pixel_renderer.sv
// top level of the monochrome tile and sprite pixel renderer
// depends on mtspr_pkg, mtspr_front, mtspr_back
`default_nettype none
// usage
//   command channel: a transaction is taken at a clock edge with start high
//   and busy low; op picks render, video memory write or sprite table write
//   config port: cfg_we with cfg_index and cfg_data writes one register at once
//   result: shade is valid for one cycle while done is high; no stall possible
// queue and sequencing
//   a two-entry queue sits between front and back; busy is high while it is full
//   writes are done by the back end in its idle state and give no result
//   a render pass fetches the bg map byte and the tile low and high bytes,
//   then scans every sprite entry (four table reads and two tile reads
//   on the single video memory port), then optionally re-fetches the
//   window tile; with the display off it skips from the map fetch to output
//   done is registered from the output step, in which shade is also set
//   off-screen renders and unknown ops are dropped at the front end
// reset
//   rst clears the queue, the sequencer, done and the config registers; memories hold
//   garbage until written
module mono_tile_sprite_pixel_renderer (
  input wire clk,
  input wire rst,
  input wire start,
  output logic busy,
  input wire [1:0] op,
  input wire [12:0] mem_addr,
  input wire [7:0] mem_data,
  input wire [7:0] line,
  input wire [7:0] column,
  input wire cfg_we,
  input wire [2:0] cfg_index,
  input wire [7:0] cfg_data,
  output logic done,
  output logic [1:0] shade
);
  logic [7:0] lcd_control, scroll_x, scroll_y, window_x, window_y;
  logic [7:0] bg_palette, sprite_palette_zero, sprite_palette_one;
  logic q_valid, q_pop;
  mtspr_pkg::item_t q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= 8'd0;
      scroll_x <= 8'd0;
      scroll_y <= 8'd0;
      window_x <= 8'd0;
      window_y <= 8'd0;
      bg_palette <= 8'd0;
      sprite_palette_zero <= 8'd0;
      sprite_palette_one <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mtspr_pkg::REG_LCDC: lcd_control <= cfg_data;
        mtspr_pkg::REG_SCX: scroll_x <= cfg_data;
        mtspr_pkg::REG_SCY: scroll_y <= cfg_data;
        mtspr_pkg::REG_WX: window_x <= cfg_data;
        mtspr_pkg::REG_WY: window_y <= cfg_data;
        mtspr_pkg::REG_BGP: bg_palette <= cfg_data;
        mtspr_pkg::REG_OBP0: sprite_palette_zero <= cfg_data;
        mtspr_pkg::REG_OBP1: sprite_palette_one <= cfg_data;
        default: ;
      endcase
    end
  end

  mtspr_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .mem_addr(mem_addr), .mem_data(mem_data), .line(line), .column(column),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  mtspr_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .lcd_control(lcd_control), .scroll_x(scroll_x), .scroll_y(scroll_y),
    .window_x(window_x), .window_y(window_y), .bg_palette(bg_palette),
    .sprite_palette_zero(sprite_palette_zero), .sprite_palette_one(sprite_palette_one),
    .done(done), .shade(shade)
  );
endmodule
`default_nettype wire

FILE: rtl/core/mtspr_front.sv
// front end: accepts items, drops ones with no effect, two-entry queue
// depends on mtspr_pkg
`default_nettype none
module mtspr_front (
  input wire clk,
  input wire rst,
  input wire start,
  output logic busy,
  input wire [1:0] op,
  input wire [12:0] mem_addr,
  input wire [7:0] mem_data,
  input wire [7:0] line,
  input wire [7:0] column,
  output logic q_valid,
  output mtspr_pkg::item_t q_item,
  input wire q_pop
);
  mtspr_pkg::item_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic keep, push;

  // renders off screen and unknown ops give nothing
  always_comb begin
    keep = (op == mtspr_pkg::OP_VWRITE) || (op == mtspr_pkg::OP_SWRITE) ||
           ((op == mtspr_pkg::OP_RENDER) && ({1'b0, line} < 9'(mtspr_pkg::ScreenHeight)) &&
            ({1'b0, column} < 9'(mtspr_pkg::ScreenWidth)));
  end

  assign busy = (count == 2'd2);
  assign push = start && !busy && keep;
  assign q_valid = (count != 2'd0);
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op, addr: mem_addr, data: mem_data, line: line, column: column};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> busy) else $error("full queue not busy");
endmodule
`default_nettype wire

FILE: rtl/core/mtspr_back.sv
// back end: memories, sequencer for writes and per-pixel fetch and sprite scan
// depends on mtspr_pkg
`default_nettype none
module mtspr_back (
  input wire clk,
  input wire rst,
  input wire q_valid,
  input mtspr_pkg::item_t q_item,
  output logic q_pop,
  input wire [7:0] lcd_control,
  input wire [7:0] scroll_x,
  input wire [7:0] scroll_y,
  input wire [7:0] window_x,
  input wire [7:0] window_y,
  input wire [7:0] bg_palette,
  input wire [7:0] sprite_palette_zero,
  input wire [7:0] sprite_palette_one,
  output logic done,
  output logic [1:0] shade
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BG_MAP = 4'd1;
  localparam logic [3:0] S_BG_LO = 4'd2;
  localparam logic [3:0] S_BG_HI = 4'd3;
  localparam logic [3:0] S_SP_Y = 4'd4;
  localparam logic [3:0] S_SP_X = 4'd5;
  localparam logic [3:0] S_SP_T = 4'd6;
  localparam logic [3:0] S_SP_A = 4'd7;
  localparam logic [3:0] S_SP_LO = 4'd8;
  localparam logic [3:0] S_SP_HI = 4'd9;
  localparam logic [3:0] S_WIN = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [7:0] vram [mtspr_pkg::VideoBytes];
  logic [7:0] otab [mtspr_pkg::TableBytes];
  logic [7:0] vdata, odata;
  logic [12:0] vaddr;
  logic [mtspr_pkg::SaW-1:0] oaddr;
  logic [3:0] state, state_next;
  mtspr_pkg::item_t it;
  logic [mtspr_pkg::SiW-1:0] spr;
  logic [7:0] ty, tx, tidx, lo, sy, sx, stile, sattr;
  logic is_win;
  logic [1:0] bg_dot, spr_shade;
  logic have_spr;
  logic vwe, owe;

  // tile pixel address helpers
  logic [12:0] tile_row_addr;
  logic [12:0] map_base;
  logic [7:0] idx_now, attr_now;
  logic [7:0] dy, dx;
  logic [3:0] row;
  logic [2:0] px;
  logic in_y, in_x, sp_ok, win_on;
  logic [7:0] stile_eff;
  logic [1:0] sdot, tdot;
  logic [2:0] tbit;

  assign vwe = (state == S_IDLE) && q_valid && (q_item.op == mtspr_pkg::OP_VWRITE);
  assign owe = (state == S_IDLE) && q_valid && (q_item.op == mtspr_pkg::OP_SWRITE) &&
               ({1'b0, q_item.addr} < 14'(mtspr_pkg::TableBytes));

  always_ff @(posedge clk) begin
    if (vwe) vram[q_item.addr] <= q_item.data;
    vdata <= vram[vaddr];
  end
  always_ff @(posedge clk) begin
    if (owe) otab[q_item.addr[mtspr_pkg::SaW-1:0]] <= q_item.data;
    odata <= otab[oaddr];
  end

  always_comb begin
    // map byte and attribute byte are still on the read port in their fetch step
    idx_now = (state == S_BG_LO) ? vdata : tidx;
    attr_now = (state == S_SP_LO) ? odata : sattr;
    if (lcd_control[4]) tile_row_addr = {1'b0, idx_now, ty[2:0], 1'b0};
    else tile_row_addr = mtspr_pkg::TileSigned + {1'b0, idx_now ^ 8'h80, ty[2:0], 1'b0};
    if (is_win) map_base = lcd_control[6] ? mtspr_pkg::MapHigh : mtspr_pkg::MapLow;
    else map_base = lcd_control[3] ? mtspr_pkg::MapHigh : mtspr_pkg::MapLow;
    dy = it.line + 8'd16 - sy;
    dx = it.column + 8'd8 - sx;
    in_y = lcd_control[2] ? (dy < 8'd16) : (dy < 8'd8);
    in_x = dx < 8'd8;
    sp_ok = (sy != 8'd0) && ({1'b0, sy} < 9'(mtspr_pkg::ScreenHeight + 16)) &&
            (sx != 8'd0) && ({1'b0, sx} < 9'(mtspr_pkg::ScreenWidth + 8)) && in_y && in_x;
    row = attr_now[6] ? ((lcd_control[2] ? 4'd15 : 4'd7) - dy[3:0]) : dy[3:0];
    px = attr_now[5] ? (3'd7 - dx[2:0]) : dx[2:0];
    stile_eff = lcd_control[2] ? {stile[7:1], 1'b0} : stile;
    sdot = {vdata[3'd7 - px], lo[3'd7 - px]};
    tbit = 3'd7 - tx[2:0];
    tdot = {vdata[tbit], lo[tbit]};
    win_on = lcd_control[5] && (window_y <= it.line) && (window_x >= 8'd7) &&
             (it.column >= window_x - 8'd7);
  end

  // sequencer with sprite loop and window fetch reuse of the bg states
  always_comb begin
    state_next = state;
    vaddr = 13'd0;
    oaddr = {spr, 2'd0};
    q_pop = 1'b0;
    case (state)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_item.op == mtspr_pkg::OP_RENDER) state_next = S_BG_MAP;
      end
      S_BG_MAP: begin
        vaddr = map_base + {3'd0, ty[7:3], tx[7:3]};
        state_next = lcd_control[7] ? S_BG_LO : S_OUT;
      end
      S_BG_LO: begin
        vaddr = tile_row_addr;
        state_next = S_BG_HI;
      end
      S_BG_HI: begin
        vaddr = tile_row_addr + 13'd1;
        state_next = S_SP_Y;
      end
      S_SP_Y: begin
        oaddr = {spr, 2'd0};
        state_next = is_win ? S_OUT : S_SP_X;
      end
      S_SP_X: begin
        oaddr = {spr, 2'd1};
        state_next = S_SP_T;
      end
      S_SP_T: begin
        oaddr = {spr, 2'd2};
        state_next = S_SP_A;
      end
      S_SP_A: begin
        oaddr = {spr, 2'd3};
        state_next = S_SP_LO;
      end
      S_SP_LO: begin
        vaddr = {1'b0, stile_eff, 4'd0} + {8'd0, row, 1'b0};
        state_next = S_SP_HI;
      end
      S_SP_HI: begin
        vaddr = {1'b0, stile_eff, 4'd0} + {8'd0, row, 1'b1};
        state_next = S_WIN;
      end
      S_WIN: begin
        if (spr != mtspr_pkg::LastSprite) state_next = S_SP_Y;
        else if (win_on) state_next = S_BG_MAP;
        else state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_valid) begin
        it <= q_item;
        ty <= scroll_y + q_item.line;
        tx <= scroll_x + q_item.column;
        is_win <= 1'b0;
        bg_dot <= 2'd0;
        have_spr <= 1'b0;
        spr <= '0;
      end
      S_BG_LO: tidx <= vdata;
      S_BG_HI: lo <= vdata;
      S_SP_Y: begin
        // window dot replaces the bg dot, bg dot is taken before the first sprite
        if (is_win) bg_dot <= tdot;
        else if (spr == '0) bg_dot <= lcd_control[0] ? tdot : 2'd0;
      end
      S_SP_X: sy <= odata;
      S_SP_T: sx <= odata;
      S_SP_A: stile <= odata;
      S_SP_LO: sattr <= odata;
      S_SP_HI: lo <= vdata;
      S_WIN: begin
        if (sp_ok && sdot != 2'd0 && !(sattr[7] && bg_dot != 2'd0)) begin
          have_spr <= 1'b1;
          spr_shade <= mtspr_pkg::map_shade(sattr[4] ? sprite_palette_one
                                            : sprite_palette_zero, sdot);
        end
        if (spr != mtspr_pkg::LastSprite) begin
          spr <= spr + 1'b1;
        end else if (win_on) begin
          is_win <= 1'b1;
          ty <= it.line - window_y;
          tx <= it.column - (window_x - 8'd7);
        end
      end
      S_OUT: begin
        if (!lcd_control[7]) shade <= 2'd0;
        else if (have_spr && !is_win) shade <= spr_shade;
        else shade <= mtspr_pkg::map_shade(bg_palette, bg_dot);
      end
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE)) else $error("pop outside idle");
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT)) else $error("strobe without output step");
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double strobe");
endmodule
`default_nettype wire
